[rtl/wot_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wot_pkg: shared types and constants of the word occurrence table
// Opcodes, status codes, field widths and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package wot_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned KEY_BYTES_DEF = 32;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned ENTRY_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Request state as it travels from cell to cell
  typedef struct packed {
    logic               valid;
    logic [OP_W-1:0]    op;
    logic               found;
    logic               free_seen;
    logic [COUNT_W-1:0] count;
  } tok_t;

endpackage
`default_nettype wire

[rtl/wot_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wot_req_if: request channel
// Valid/ready channel carrying the opcode and the four key words.
// ----------------------------------------------------------------------------
interface wot_req_if;
  logic                       valid;
  logic                       ready;
  logic [wot_pkg::OP_W-1:0]   opcode;
  logic [wot_pkg::WORD_W-1:0] key_word0;
  logic [wot_pkg::WORD_W-1:0] key_word1;
  logic [wot_pkg::WORD_W-1:0] key_word2;
  logic [wot_pkg::WORD_W-1:0] key_word3;

  modport source (output valid, opcode, key_word0, key_word1, key_word2, key_word3,
                  input ready);
  modport sink (input valid, opcode, key_word0, key_word1, key_word2, key_word3,
                output ready);
endinterface
`default_nettype wire

[rtl/wot_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wot_rsp_if: response channel
// Valid/ready channel carrying status, count and the number of used slots.
// ----------------------------------------------------------------------------
interface wot_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [wot_pkg::ST_W-1:0]    status;
  logic [wot_pkg::COUNT_W-1:0] count;
  logic [wot_pkg::ENTRY_W-1:0] entries_used;

  modport source (output valid, status, count, entries_used, input ready);
  modport sink (input valid, status, count, entries_used, output ready);
endinterface
`default_nettype wire

[rtl/wot_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wot_cell: one slot of the table
// Holds a key, its count and a valid bit; updates the passing token and
// hands it to the next cell through its token register.
// ----------------------------------------------------------------------------
module wot_cell #(
  parameter int unsigned KEY_BYTES = wot_pkg::KEY_BYTES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire wot_pkg::tok_t          tok_i,
  input  wire logic [KEY_BYTES*8-1:0] key_i,
  input  wire logic                   claim_i,
  output wot_pkg::tok_t               tok_o
);

  localparam int unsigned KeyW = KEY_BYTES * 8;

  logic                        valid_q;
  logic                        first_free_q;
  logic [KeyW-1:0]             key_q;
  logic [wot_pkg::COUNT_W-1:0] count_q;
  logic [wot_pkg::COUNT_W-1:0] count_inc;
  wot_pkg::tok_t               tok_d;
  wot_pkg::tok_t               tok_q;
  logic                        hit;
  logic                        mark_free;

  assign hit       = tok_i.valid && valid_q && (key_q == key_i);
  assign mark_free = tok_i.valid && !valid_q && !tok_i.free_seen;
  assign count_inc = (count_q == '1) ? count_q : count_q + wot_pkg::COUNT_W'(1);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      case (tok_i.op)
        wot_pkg::OP_INSERT: tok_d.count = count_inc;
        wot_pkg::OP_LOOKUP: tok_d.count = count_q;
        default:            tok_d.count = tok_i.count;
      endcase
    end
    if (mark_free) begin
      tok_d.free_seen = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      first_free_q <= 1'b0;
      tok_q        <= '0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.valid) begin
        first_free_q <= mark_free;
      end
      if (hit && tok_i.op == wot_pkg::OP_REMOVE) begin
        valid_q <= 1'b0;
      end
      if (claim_i && first_free_q) begin
        valid_q <= 1'b1;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (hit && tok_i.op == wot_pkg::OP_INSERT) begin
      count_q <= count_inc;
    end
    if (claim_i && first_free_q) begin
      key_q   <= key_i;
      count_q <= wot_pkg::COUNT_W'(1);
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

[rtl/wot_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wot_ctrl: request sequencer
// Trims the key to its string form, launches a token into the cell chain,
// collects it at the far end, claims a free slot and registers the response.
// ----------------------------------------------------------------------------
module wot_ctrl #(
  parameter int unsigned SLOTS     = wot_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BYTES = wot_pkg::KEY_BYTES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  wot_req_if.sink                     req_i,
  wot_rsp_if.source                   rsp_o,
  output wot_pkg::tok_t               tok_o,
  input  wire wot_pkg::tok_t          tok_i,
  output logic [KEY_BYTES*8-1:0]      key_o,
  output logic                        claim_o
);

  localparam int unsigned KeyW   = KEY_BYTES * 8;
  localparam int unsigned UsedW  = $clog2(SLOTS + 1);
  localparam int unsigned RawW   = 4 * wot_pkg::WORD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_e;

  state_e                      state_q;
  wot_pkg::tok_t               launch_q;
  wot_pkg::tok_t               end_q;
  logic [UsedW-1:0]            used_q;
  logic [UsedW-1:0]            used_d;
  logic [KeyW-1:0]             key_q;
  logic [KeyW-1:0]             key_canon;
  logic [RawW-1:0]             raw;
  logic                        rsp_valid_q;
  logic [wot_pkg::ST_W-1:0]    rsp_status_q;
  logic [wot_pkg::COUNT_W-1:0] rsp_count_q;
  logic [wot_pkg::ST_W-1:0]    st_d;
  logic [wot_pkg::COUNT_W-1:0] cnt_d;
  logic [UsedW+wot_pkg::ENTRY_W-1:0] used_ext;
  logic                        accept;
  logic                        out_free;
  logic                        fin;

  assign raw = {req_i.key_word3, req_i.key_word2, req_i.key_word1, req_i.key_word0};

  // Zero every byte from the first zero byte on
  always_comb begin
    logic ended;
    logic [7:0] b;
    ended = 1'b0;
    key_canon = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = raw[i*8 +: 8];
      if (ended) begin
        b = 8'd0;
      end
      if (b == 8'd0) begin
        ended = 1'b1;
      end
      key_canon[i*8 +: 8] = b;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign fin         = (state_q == S_FINISH) && out_free;
  assign claim_o     = fin && end_q.op == wot_pkg::OP_INSERT && !end_q.found &&
                       end_q.free_seen;

  always_comb begin
    st_d   = wot_pkg::ST_OK;
    cnt_d  = '0;
    used_d = used_q;
    case (end_q.op)
      wot_pkg::OP_INSERT: begin
        if (end_q.found) begin
          cnt_d = end_q.count;
        end else if (end_q.free_seen) begin
          cnt_d  = wot_pkg::COUNT_W'(1);
          used_d = used_q + UsedW'(1);
        end else begin
          st_d = wot_pkg::ST_FULL;
        end
      end
      wot_pkg::OP_REMOVE: begin
        if (end_q.found) begin
          if (used_q != '0) begin
            used_d = used_q - UsedW'(1);
          end
        end else begin
          st_d = wot_pkg::ST_NOT_FOUND;
        end
      end
      wot_pkg::OP_LOOKUP: cnt_d = end_q.count;
      default:            cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      launch_q     <= '0;
      end_q        <= '0;
      used_q       <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_count_q  <= '0;
    end else begin
      // the token lives for one cycle at the head of the chain
      launch_q.valid <= accept;
      if (fin) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            launch_q.op        <= req_i.opcode;
            launch_q.found     <= 1'b0;
            launch_q.free_seen <= 1'b0;
            launch_q.count     <= '0;
            state_q            <= S_WALK;
          end
        end
        S_WALK: begin
          if (tok_i.valid) begin
            end_q   <= tok_i;
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            rsp_status_q <= st_d;
            rsp_count_q  <= cnt_d;
            used_q       <= used_d;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_canon;
    end
  end

  assign used_ext          = {{wot_pkg::ENTRY_W{1'b0}}, used_q};
  assign tok_o             = launch_q;
  assign key_o             = key_q;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.count       = rsp_count_q;
  assign rsp_o.entries_used = used_ext[wot_pkg::ENTRY_W-1:0];

endmodule
`default_nettype wire

[rtl/word_occurrence_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// word_occurrence_table: bounded table of string keys with occurrence counts
// Usage:
//   req_i carries an opcode (insert/count, remove, look up) and a key of up to
//   KEY_BYTES bytes over four 64-bit words; bytes after the first zero byte
//   are ignored. rsp_o returns status, count and the number of used slots,
//   one response per request, in order.
//   The table is a row of SLOTS cells. A request token enters the first cell
//   and moves one cell per cycle; each cell compares the held key against
//   its own slot and notes the first free slot. At the far end an insert of a
//   new key writes it into the noted free slot.
//   One request is in flight at a time: the next is taken only once the
//   last token has walked the cell chain and its response is registered.
//   A stalled receiver holds the response in the output register; the next
//   request is taken while it waits, and its result waits behind it.
//   Reset empties every slot and clears the used count; no clearing pass.
// ----------------------------------------------------------------------------
module word_occurrence_table #(
  parameter int unsigned SLOTS     = wot_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BYTES = wot_pkg::KEY_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wot_req_if.sink   req_i,
  wot_rsp_if.source rsp_o
);

  localparam int unsigned KeyW = KEY_BYTES * 8;

  wot_pkg::tok_t   tok_w [SLOTS+1];
  logic [KeyW-1:0] key_w;
  logic            claim_w;

  wot_ctrl #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .tok_o   (tok_w[0]),
    .tok_i   (tok_w[SLOTS]),
    .key_o   (key_w),
    .claim_o (claim_w)
  );

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    wot_cell #(
      .KEY_BYTES (KEY_BYTES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok_w[g]),
      .key_i   (key_w),
      .claim_i (claim_w),
      .tok_o   (tok_w[g+1])
    );
  end

endmodule
`default_nettype wire
